/* rtl/wsd_pkg.sv */
// Shared types, codes and result builders for the WebSocket frame decoder.
package wsd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_SHORT_HDR   = 3'd1;
  localparam logic [2:0] ERR_SHORT_LEN16 = 3'd2;
  localparam logic [2:0] ERR_SHORT_LEN64 = 3'd3;
  localparam logic [2:0] ERR_SHORT_KEY   = 3'd4;
  localparam logic [2:0] ERR_SHORT_PAY   = 3'd5;

  // Parse phases
  localparam logic [2:0] PH_B0    = 3'd0;
  localparam logic [2:0] PH_B1    = 3'd1;
  localparam logic [2:0] PH_EXT16 = 3'd2;
  localparam logic [2:0] PH_EXT64 = 3'd3;
  localparam logic [2:0] PH_KEY   = 3'd4;
  localparam logic [2:0] PH_PAY   = 3'd5;

  // Header length forms
  localparam logic [6:0] LEN7_MAX   = 7'd125;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [31:0] mask_key;
    logic [2:0]  error_code;
    logic        frame_end;
  } result_t;

  // Write enables from the parser toward the result queue
  typedef struct packed {
    logic push0;
    logic push1;
  } push_t;

  function automatic result_t make_frame(logic [1:0] kind, logic [7:0] pb, logic fin,
                                         logic [3:0] opcode, logic masked,
                                         logic [63:0] len, logic [31:0] key,
                                         logic frame_end);
    result_t r;
    r.kind           = kind;
    r.payload_byte   = pb;
    r.fin            = fin;
    r.opcode         = opcode;
    r.masked         = masked;
    r.payload_length = len;
    r.mask_key       = key;
    r.error_code     = ERR_NONE;
    r.frame_end      = frame_end;
    return r;
  endfunction

  function automatic result_t make_err(logic [2:0] code);
    result_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

endpackage

/* rtl/wsd_ifs.sv */
// Valid/ready channel interfaces for the decoder's byte input and result output.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        fin;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] payload_length;
  logic [31:0] mask_key;
  logic [2:0]  error_code;
  logic        frame_end;

  modport source (output valid, output kind, output payload_byte, output fin,
                  output opcode, output masked, output payload_length,
                  output mask_key, output error_code, output frame_end,
                  input ready);
  modport sink (input valid, input kind, input payload_byte, input fin,
                input opcode, input masked, input payload_length,
                input mask_key, input error_code, input frame_end,
                output ready);
endinterface

/* rtl/wsd_parser.sv */
// Input byte register and single-pass frame parse step producing up to two results.
module wsd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [7:0]           in_data,
  input  logic                 in_last,
  output logic                 in_ready,
  input  logic                 room,
  output wsd_pkg::push_t       push,
  output wsd_pkg::result_t     res0,
  output wsd_pkg::result_t     res1
);

  logic       inq_valid;
  logic [7:0] inq_data;
  logic       inq_last;
  logic       fire;

  logic [2:0]  phase, phase_next;
  logic [3:0]  ext_left, ext_left_next;
  logic [63:0] length_accum, length_accum_next;
  logic [63:0] payload_left, payload_left_next;
  logic [31:0] key_reg, key_reg_next;
  logic [1:0]  key_index, key_index_next;
  logic        fin_reg, fin_reg_next;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic        masked_reg, masked_reg_next;

  logic       after_len;
  logic       hdr_done;
  logic [7:0] key_byte;
  logic [7:0] pb;
  logic [1:0] n_res;

  assign fire     = inq_valid && room;
  assign in_ready = !inq_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      inq_data <= in_data;
      inq_last <= in_last;
    end
  end

  // Key byte for the current payload position, first key byte first
  always_comb begin
    unique case (key_index)
      2'd0: key_byte = key_reg[31:24];
      2'd1: key_byte = key_reg[23:16];
      2'd2: key_byte = key_reg[15:8];
      default: key_byte = key_reg[7:0];
    endcase
  end

  assign pb = inq_data ^ key_byte;

  always_comb begin
    phase_next        = phase;
    ext_left_next     = ext_left;
    length_accum_next = length_accum;
    payload_left_next = payload_left;
    key_reg_next      = key_reg;
    key_index_next    = key_index;
    fin_reg_next      = fin_reg;
    opcode_reg_next   = opcode_reg;
    masked_reg_next   = masked_reg;
    after_len         = 1'b0;
    hdr_done          = 1'b0;
    n_res             = 2'd0;
    res0              = '0;
    res1              = '0;

    unique case (phase)
      wsd_pkg::PH_B1: begin
        masked_reg_next = inq_data[7];
        if (inq_data[6:0] <= wsd_pkg::LEN7_MAX) begin
          length_accum_next = {57'd0, inq_data[6:0]};
          after_len         = 1'b1;
        end else if (inq_data[6:0] == wsd_pkg::LEN7_EXT16) begin
          ext_left_next = wsd_pkg::EXT16_BYTES;
          phase_next    = wsd_pkg::PH_EXT16;
          if (inq_last) begin
            res0       = wsd_pkg::make_err(wsd_pkg::ERR_SHORT_LEN16);
            n_res      = 2'd1;
            phase_next = wsd_pkg::PH_B0;
          end
        end else begin
          ext_left_next = wsd_pkg::EXT64_BYTES;
          phase_next    = wsd_pkg::PH_EXT64;
          if (inq_last) begin
            res0       = wsd_pkg::make_err(wsd_pkg::ERR_SHORT_LEN64);
            n_res      = 2'd1;
            phase_next = wsd_pkg::PH_B0;
          end
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        length_accum_next = {length_accum[55:0], inq_data};
        ext_left_next     = ext_left - 4'd1;
        if (ext_left_next == 4'd0) begin
          after_len = 1'b1;
        end else if (inq_last) begin
          res0       = wsd_pkg::make_err((phase == wsd_pkg::PH_EXT16) ?
                                         wsd_pkg::ERR_SHORT_LEN16 :
                                         wsd_pkg::ERR_SHORT_LEN64);
          n_res      = 2'd1;
          phase_next = wsd_pkg::PH_B0;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_reg_next = {key_reg[23:0], inq_data};
        if (key_index == 2'd3) begin
          hdr_done = 1'b1;
        end else begin
          key_index_next = key_index + 2'd1;
          if (inq_last) begin
            res0       = wsd_pkg::make_err(wsd_pkg::ERR_SHORT_KEY);
            n_res      = 2'd1;
            phase_next = wsd_pkg::PH_B0;
          end
        end
      end
      wsd_pkg::PH_PAY: begin
        key_index_next    = key_index + 2'd1;
        payload_left_next = payload_left - 64'd1;
        n_res             = 2'd1;
        if (payload_left_next == 64'd0) begin
          res0       = wsd_pkg::make_frame(wsd_pkg::KIND_PAYLOAD, pb, fin_reg, opcode_reg,
                                           masked_reg, length_accum, key_reg, 1'b1);
          phase_next = wsd_pkg::PH_B0;
        end else begin
          res0 = wsd_pkg::make_frame(wsd_pkg::KIND_PAYLOAD, pb, fin_reg, opcode_reg,
                                     masked_reg, length_accum, key_reg, 1'b0);
          if (inq_last) begin
            res1       = wsd_pkg::make_err(wsd_pkg::ERR_SHORT_PAY);
            n_res      = 2'd2;
            phase_next = wsd_pkg::PH_B0;
          end
        end
      end
      default: begin
        // First header byte; unused phase codes land here too
        fin_reg_next      = inq_data[7];
        opcode_reg_next   = inq_data[3:0];
        masked_reg_next   = 1'b0;
        length_accum_next = '0;
        payload_left_next = '0;
        key_reg_next      = '0;
        key_index_next    = 2'd0;
        ext_left_next     = 4'd0;
        if (inq_last) begin
          res0       = wsd_pkg::make_err(wsd_pkg::ERR_SHORT_HDR);
          n_res      = 2'd1;
          phase_next = wsd_pkg::PH_B0;
        end else begin
          phase_next = wsd_pkg::PH_B1;
        end
      end
    endcase

    // Length known: collect the key, or finish the header
    if (after_len) begin
      if (masked_reg_next) begin
        key_index_next = 2'd0;
        if (inq_last) begin
          res0       = wsd_pkg::make_err(wsd_pkg::ERR_SHORT_KEY);
          n_res      = 2'd1;
          phase_next = wsd_pkg::PH_B0;
        end else begin
          phase_next = wsd_pkg::PH_KEY;
        end
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      payload_left_next = length_accum_next;
      key_index_next    = 2'd0;
      n_res             = 2'd1;
      if (length_accum_next == 64'd0) begin
        res0       = wsd_pkg::make_frame(wsd_pkg::KIND_HEADER, 8'd0, fin_reg_next,
                                         opcode_reg_next, masked_reg_next,
                                         length_accum_next, key_reg_next, 1'b1);
        phase_next = wsd_pkg::PH_B0;
      end else begin
        res0 = wsd_pkg::make_frame(wsd_pkg::KIND_HEADER, 8'd0, fin_reg_next,
                                   opcode_reg_next, masked_reg_next,
                                   length_accum_next, key_reg_next, 1'b0);
        if (inq_last) begin
          res1       = wsd_pkg::make_err(wsd_pkg::ERR_SHORT_PAY);
          n_res      = 2'd2;
          phase_next = wsd_pkg::PH_B0;
        end else begin
          phase_next = wsd_pkg::PH_PAY;
        end
      end
    end
  end

  assign push.push0 = fire && (n_res != 2'd0);
  assign push.push1 = fire && (n_res == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wsd_pkg::PH_B0;
      ext_left  <= 4'd0;
      key_index <= 2'd0;
    end else if (fire) begin
      phase     <= phase_next;
      ext_left  <= ext_left_next;
      key_index <= key_index_next;
    end
    if (fire) begin
      length_accum <= length_accum_next;
      payload_left <= payload_left_next;
      key_reg      <= key_reg_next;
      fin_reg      <= fin_reg_next;
      opcode_reg   <= opcode_reg_next;
      masked_reg   <= masked_reg_next;
    end
  end

endmodule

/* rtl/wsd_result_fifo.sv */
// Four-entry result queue taking up to two results per cycle and giving one.
module wsd_result_fifo (
  input  logic             clk,
  input  logic             rst,
  input  wsd_pkg::push_t   push,
  input  wsd_pkg::result_t res0,
  input  wsd_pkg::result_t res1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_pkg::result_t out_res
);

  wsd_pkg::result_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] n_push;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign out_res   = mem[rd_ptr];
  // Room for two more regardless of a pop this cycle
  assign room      = (count <= 3'd2);
  assign n_push    = {2'b00, push.push0} + {2'b00, push.push1};

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= res0;
    end
    if (push.push1) begin
      mem[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + n_push[1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + n_push - {2'b00, pop};
    end
  end

endmodule

/* rtl/websocket_frame_decoder.sv */
// WebSocket frame decoder: one raw byte per cycle in, header/payload/error results out.
// A result passes through the input byte register, then the parse step writes it
// into the result queue. Throughput: one byte per cycle while the queue has room
// for two results; a byte that yields two results (payload or header followed by
// a short-payload error) is absorbed by the 4-entry queue.
// Reset (rst, synchronous, active high): parser expects the first header byte, queue empty.
module websocket_frame_decoder (
  input  logic      clk,
  input  logic      rst,
  wsd_in_if.sink    rx,
  wsd_out_if.source tx
);

  wsd_pkg::push_t   push;
  wsd_pkg::result_t res0;
  wsd_pkg::result_t res1;
  wsd_pkg::result_t out_res;
  logic             room;

  // Parse one registered byte per cycle whenever the queue can take two results
  wsd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_data  (rx.data_byte),
    .in_last  (rx.last_byte),
    .in_ready (rx.ready),
    .room     (room),
    .push     (push),
    .res0     (res0),
    .res1     (res1)
  );

  // Hold results until the sink takes each item
  wsd_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_res   (out_res)
  );

  // Fan the queued result out onto the channel fields
  assign tx.kind           = out_res.kind;
  assign tx.payload_byte   = out_res.payload_byte;
  assign tx.fin            = out_res.fin;
  assign tx.opcode         = out_res.opcode;
  assign tx.masked         = out_res.masked;
  assign tx.payload_length = out_res.payload_length;
  assign tx.mask_key       = out_res.mask_key;
  assign tx.error_code     = out_res.error_code;
  assign tx.frame_end      = out_res.frame_end;

endmodule

/* rtl/wsd_checker.sv */
// Port-level checks for the WebSocket frame decoder, bound to the top level.
module wsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        tx_valid,
  input logic        tx_ready,
  input logic [1:0]  tx_kind,
  input logic [63:0] tx_payload_length,
  input logic [2:0]  tx_error_code,
  input logic        tx_frame_end
);

  // Hold an offered item until taken
  assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid)
    else $error("result item dropped while stalled");

  // Queue is empty after reset
  assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("result offered right after reset");

  // Error items carry a real code, no frame end and a zero payload length
  assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_kind == wsd_pkg::KIND_ERROR |->
      tx_error_code != wsd_pkg::ERR_NONE && !tx_frame_end && tx_payload_length == 64'd0)
    else $error("malformed error item");

  // Non-error items carry no error code and a known kind
  assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_kind != wsd_pkg::KIND_ERROR |->
      tx_error_code == wsd_pkg::ERR_NONE &&
      (tx_kind == wsd_pkg::KIND_PAYLOAD || tx_kind == wsd_pkg::KIND_HEADER))
    else $error("bad kind or stray error code");

endmodule

bind websocket_frame_decoder wsd_checker u_wsd_checker (
  .clk               (clk),
  .rst               (rst),
  .tx_valid          (tx.valid),
  .tx_ready          (tx.ready),
  .tx_kind           (tx.kind),
  .tx_payload_length (tx.payload_length),
  .tx_error_code     (tx.error_code),
  .tx_frame_end      (tx.frame_end)
);

/* dv/tb_websocket_frame_decoder.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the WebSocket frame decoder: byte stream in, checked results out.
module tb_websocket_frame_decoder;

  // Length forms of a generated frame header
  localparam int FORM_LEN7  = 0;
  localparam int FORM_LEN16 = 1;
  localparam int FORM_LEN64 = 2;

  // 7-bit length code that announces a 64-bit extended length
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam int ITEM_TARGET  = 700;
  localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int SETTLE_TIME  = 12;    // wait after the last owed result has come back, in clock periods
  localparam int HOLDOFF_LONG = 80;    // receiver hold-off, well past the result queue depth

  logic clk;
  logic rst;

  wsd_in_if  rx_ch ();
  wsd_out_if tx_ch ();

  websocket_frame_decoder dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .tx (tx_ch)
  );

  // Results the decoder owes us, oldest first
  wsd_pkg::result_t awaited_results[$];

  int mismatch_count;
  int sent_count;
  int stalled_cycles;
  int holdoff_request;
  int holdoff_left;
  bit src_gaps_on;
  bit sink_stalls_on;

  // Parser state as the decoder should hold it
  logic [2:0]  phase_now;
  logic [3:0]  ext_remaining;
  logic [63:0] frame_len;
  logic [63:0] bytes_to_go;
  logic [31:0] key_word;
  logic [1:0]  key_pos;
  logic        fin_bit;
  logic [3:0]  op_bits;
  logic        mask_bit;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame parser prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parser();
    phase_now     = wsd_pkg::PH_B0;
    ext_remaining = '0;
    frame_len     = '0;
    bytes_to_go   = '0;
    key_word      = '0;
    key_pos       = '0;
    fin_bit       = 1'b0;
    op_bits       = '0;
    mask_bit      = 1'b0;
  endfunction

  // Queue a header or payload result carrying the current frame's fields.
  function automatic void owe_frame_result(logic [1:0] kind, logic [7:0] data, logic done);
    wsd_pkg::result_t r;
    r.kind           = kind;
    r.payload_byte   = data;
    r.fin            = fin_bit;
    r.opcode         = op_bits;
    r.masked         = mask_bit;
    r.payload_length = frame_len;
    r.mask_key       = key_word;
    r.error_code     = wsd_pkg::ERR_NONE;
    r.frame_end      = done;
    awaited_results.push_back(r);
  endfunction

  // Error results carry only the kind and the code; everything else is zero.
  function automatic void owe_error(logic [2:0] code);
    wsd_pkg::result_t r;
    r            = '0;
    r.kind       = wsd_pkg::KIND_ERROR;
    r.error_code = code;
    awaited_results.push_back(r);
    phase_now    = wsd_pkg::PH_B0;
  endfunction

  // Header complete: announce it, then either close the frame, cut it short or
  // move on to the payload.
  function automatic void close_header(logic lst);
    bytes_to_go = frame_len;
    key_pos     = '0;
    if (frame_len == 0) begin
      owe_frame_result(wsd_pkg::KIND_HEADER, 8'h00, 1'b1);
      phase_now = wsd_pkg::PH_B0;
    end else begin
      owe_frame_result(wsd_pkg::KIND_HEADER, 8'h00, 1'b0);
      if (lst) begin
        owe_error(wsd_pkg::ERR_SHORT_PAY);
      end else begin
        phase_now = wsd_pkg::PH_PAY;
      end
    end
  endfunction

  // Length settled: collect the key if the frame is masked.
  function automatic void length_settled(logic lst);
    if (mask_bit) begin
      key_pos = '0;
      if (lst) begin
        owe_error(wsd_pkg::ERR_SHORT_KEY);
      end else begin
        phase_now = wsd_pkg::PH_KEY;
      end
    end else begin
      close_header(lst);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic lst);
    logic [6:0] len7;
    logic [7:0] key_byte;
    unique case (phase_now)
      wsd_pkg::PH_B1: begin
        mask_bit = b[7];
        len7     = b[6:0];
        if (len7 <= wsd_pkg::LEN7_MAX) begin
          frame_len = {57'd0, len7};
          length_settled(lst);
        end else begin
          if (len7 == wsd_pkg::LEN7_EXT16) begin
            ext_remaining = wsd_pkg::EXT16_BYTES;
            phase_now     = wsd_pkg::PH_EXT16;
          end else begin
            ext_remaining = wsd_pkg::EXT64_BYTES;
            phase_now     = wsd_pkg::PH_EXT64;
          end
          if (lst) owe_error(phase_now == wsd_pkg::PH_EXT16 ? wsd_pkg::ERR_SHORT_LEN16 :
                                                              wsd_pkg::ERR_SHORT_LEN64);
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        frame_len     = {frame_len[55:0], b};
        ext_remaining = ext_remaining - 4'd1;
        if (ext_remaining == 0) begin
          length_settled(lst);
        end else if (lst) begin
          owe_error(phase_now == wsd_pkg::PH_EXT16 ? wsd_pkg::ERR_SHORT_LEN16 :
                                                     wsd_pkg::ERR_SHORT_LEN64);
        end
      end
      wsd_pkg::PH_KEY: begin
        key_word = {key_word[23:0], b};
        if (key_pos == 2'd3) begin
          close_header(lst);
        end else begin
          key_pos = key_pos + 2'd1;
          if (lst) owe_error(wsd_pkg::ERR_SHORT_KEY);
        end
      end
      wsd_pkg::PH_PAY: begin
        key_byte    = key_word[8 * (3 - key_pos) +: 8];
        key_pos     = key_pos + 2'd1;
        bytes_to_go = bytes_to_go - 64'd1;
        if (bytes_to_go == 0) begin
          owe_frame_result(wsd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b1);
          phase_now = wsd_pkg::PH_B0;
        end else begin
          owe_frame_result(wsd_pkg::KIND_PAYLOAD, b ^ key_byte, 1'b0);
          if (lst) owe_error(wsd_pkg::ERR_SHORT_PAY);
        end
      end
      default: begin
        // First header byte: start a fresh frame whatever came before.
        fin_bit       = b[7];
        op_bits       = b[3:0];
        mask_bit      = 1'b0;
        frame_len     = '0;
        bytes_to_go   = '0;
        key_word      = '0;
        key_pos       = '0;
        ext_remaining = '0;
        if (lst) begin
          owe_error(wsd_pkg::ERR_SHORT_HDR);
        end else begin
          phase_now = wsd_pkg::PH_B1;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until the decoder takes it. Called at a falling
  // edge, returns at a falling edge with valid still high so that the next byte
  // can follow without a bubble.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (src_gaps_on && $urandom_range(0, 99) < 14) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.data_byte <= b;
    rx_ch.last_byte <= lst;
    do @(posedge clk); while (!rx_ch.ready);
    decode_byte(b, lst);
    sent_count++;
    @(negedge clk);
  endtask

  // Build a frame and send it, up to and including byte index cut, which
  // carries the last-byte flag. A negative cut sends the whole frame unflagged.
  task automatic play_frame(input logic [7:0] first, input logic msk, input int form,
                            input logic [63:0] len, input logic [31:0] mkey,
                            input int npay, input int cut);
    logic [7:0] frame_bytes[$];
    logic [6:0] len7;
    int         stop;
    frame_bytes.push_back(first);
    unique case (form)
      FORM_LEN16: len7 = wsd_pkg::LEN7_EXT16;
      FORM_LEN64: len7 = LEN7_EXT64;
      default:    len7 = len[6:0];
    endcase
    frame_bytes.push_back({msk, len7});
    if (form == FORM_LEN16) begin
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
    end
    if (form == FORM_LEN64) begin
      for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[8 * i +: 8]);
    end
    if (msk) begin
      for (int i = 3; i >= 0; i--) frame_bytes.push_back(mkey[8 * i +: 8]);
    end
    repeat (npay) frame_bytes.push_back(8'($urandom_range(0, 255)));
    stop = (cut >= 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size() - 1;
    for (int i = 0; i <= stop; i++) send_byte(frame_bytes[i], i == cut);
  endtask

  task automatic play_random_frame();
    int          form;
    int          pick;
    int          hdr_len;
    int          npay;
    int          cut;
    logic        msk;
    logic [63:0] len;
    pick = $urandom_range(0, 99);
    form = pick < 70 ? FORM_LEN7 : (pick < 90 ? FORM_LEN16 : FORM_LEN64);
    msk  = $urandom_range(0, 99) < 70;
    // Keep most frames short; now and then use the full range of the form.
    if ($urandom_range(0, 9) == 0) begin
      unique case (form)
        FORM_LEN7:  len = 64'($urandom_range(0, 125));
        FORM_LEN16: len = 64'($urandom_range(0, 16'hFFFF));
        default:    len = {$urandom, $urandom};
      endcase
    end else begin
      len = 64'($urandom_range(0, 12));
    end
    hdr_len = 2 + (form == FORM_LEN16 ? 2 : (form == FORM_LEN64 ? 8 : 0)) + (msk ? 4 : 0);
    if (len > 130) begin
      // Too long to send whole: cut it off inside the header tail or payload.
      npay = $urandom_range(0, 6);
      cut  = hdr_len + npay - 1;
    end else begin
      npay = int'(len);
      pick = $urandom_range(0, 99);
      if (pick < 70)      cut = -1;
      else if (pick < 85) cut = hdr_len + npay - 1;
      else                cut = $urandom_range(0, hdr_len + npay - 1);
    end
    play_frame(8'($urandom_range(0, 255)), msk, form, len, $urandom, npay, cut);
  endtask

  // Random bytes, then a flagged byte so the parser ends back at a frame start.
  task automatic play_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid and wait until every owed result has come back, then settle.
  task automatic drain_and_settle();
    rx_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_TIME) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Cut the buffer at each part of the header, and right after the header.
  task automatic test_truncation_errors();
    play_frame(8'hFF, 1'b0, FORM_LEN7, 64'd0, 32'h0, 0, 0);   // lone first byte
    play_frame(8'h81, 1'b1, FORM_LEN16, 64'd0, 32'h0, 0, 1);  // 16-bit length missing
    play_frame(8'h70, 1'b0, FORM_LEN64, 64'd0, 32'h0, 0, 1);  // 64-bit length missing
    play_frame(8'h82, 1'b1, FORM_LEN7, 64'd5, 32'h0, 0, 1);   // key missing
    play_frame(8'h01, 1'b0, FORM_LEN7, 64'd3, 32'h0, 0, 1);   // header only, payload owed
  endtask

  // Zero length, the largest 64-bit length, a full masked frame ending the buffer.
  task automatic test_length_forms();
    play_frame(8'h0F, 1'b0, FORM_LEN7, 64'd0, 32'h0, 0, 1);
    play_frame(8'h80, 1'b0, FORM_LEN64, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1, 10);
    play_frame(8'h88, 1'b1, FORM_LEN7, 64'd2, 32'hFFFF_FFFF, 2, 7);
  endtask

  // Hold the receiver off while the source keeps pushing, so the result queue
  // fills and the decoder has to stall its input.
  task automatic test_output_stall();
    src_gaps_on     = 1'b0;
    holdoff_request = HOLDOFF_LONG;
    play_frame(8'($urandom_range(0, 255)), 1'b1, FORM_LEN16, 64'd40, $urandom, 40, -1);
    src_gaps_on     = 1'b1;
  endtask

  // Full rate on both sides for a while.
  task automatic test_back_to_back();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (12) play_random_frame();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic test_random_frames();
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 8) play_noise();
      else play_random_frame();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink and checking
  // ---------------------------------------------------------------------------

  initial begin
    tx_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_request > 0) begin
        holdoff_left    = holdoff_request;
        holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        tx_ch.ready <= 1'b0;
      end else begin
        tx_ch.ready <= !(sink_stalls_on && $urandom_range(0, 99) < 14);
      end
    end
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : result_check
    wsd_pkg::result_t want;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (awaited_results.size() == 0) begin
        report($sformatf("result of kind %0d with nothing owed", tx_ch.kind));
      end else begin
        want = awaited_results.pop_front();
        compare_field("kind", 64'(tx_ch.kind), 64'(want.kind));
        compare_field("payload_byte", 64'(tx_ch.payload_byte), 64'(want.payload_byte));
        compare_field("fin", 64'(tx_ch.fin), 64'(want.fin));
        compare_field("opcode", 64'(tx_ch.opcode), 64'(want.opcode));
        compare_field("masked", 64'(tx_ch.masked), 64'(want.masked));
        compare_field("payload_length", tx_ch.payload_length, want.payload_length);
        compare_field("mask_key", 64'(tx_ch.mask_key), 64'(want.mask_key));
        compare_field("error_code", 64'(tx_ch.error_code), 64'(want.error_code));
        compare_field("frame_end", 64'(tx_ch.frame_end), 64'(want.frame_end));
      end
    end
  end

  // Give up when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst             = 1'b1;
    rx_ch.valid     = 1'b0;
    rx_ch.data_byte = 8'h00;
    rx_ch.last_byte = 1'b0;
    mismatch_count  = 0;
    sent_count      = 0;
    stalled_cycles  = 0;
    holdoff_request = 0;
    holdoff_left    = 0;
    src_gaps_on     = 1'b1;
    sink_stalls_on  = 1'b1;
    clear_parser();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_truncation_errors();
    test_length_forms();
    test_output_stall();
    test_back_to_back();
    test_random_frames();
    drain_and_settle();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/wsd_pkg.sv
rtl/wsd_ifs.sv
rtl/wsd_parser.sv
rtl/wsd_result_fifo.sv
rtl/websocket_frame_decoder.sv
rtl/wsd_checker.sv
dv/tb_websocket_frame_decoder.sv
